/* rtl/core/gee_pkg.sv */
package gee_pkg;

    // Widths of the shared arithmetic units.
    localparam int LOG_W  = 28;   // 4 integer bits, 24 fraction bits
    localparam int DIV_NW = 48;   // dividend and quotient width
    localparam int DIV_DW = 32;   // divisor and remainder width
    localparam int DIV_CW = 6;    // step counter width, holds DIV_NW

    // Fixed values of the estimator.
    localparam logic [19:0]       DEFAULT_Q12   = 20'd9093;
    localparam logic [19:0]       ONE_Q12       = 20'd4096;
    localparam logic [15:0]       LEVEL_MAX     = 16'hffff;
    localparam logic [23:0]       RATIO_POS_MAX = 24'h7fffff;
    localparam logic [23:0]       RATIO_NEG_MAX = 24'h800000;

    // Configuration register indexes.
    localparam logic [1:0] REG_TABLE_KIND     = 2'd0;
    localparam logic [1:0] REG_ELEMENT_FORMAT = 2'd1;
    localparam logic [1:0] REG_INDEX_BITS     = 2'd2;
    localparam logic [1:0] REG_TABLE_ENTRIES  = 2'd3;

    typedef enum logic {
        DIV_RATIO,
        DIV_MEAN
    } t_div_sel;

    typedef enum logic [1:0] {
        LOG_F,
        LOG_FMAX,
        LOG_H,
        LOG_HMAX
    } t_log_sel;

    typedef struct packed {
        logic        table_kind;
        logic [1:0]  element_format;
        logic [4:0]  index_bits;
        logic [16:0] table_entries;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     scale;
        logic     first;
        logic     step_nsi;
        logic     advance;
        logic     finish;
        logic     div_start;
        t_div_sel div_sel;
        logic     log_start;
        t_log_sel log_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_first;
        logic is_sample;
        logic skip;
        logic den_zero;
        logic is_last;
        logic direct;
        logic out_full;
        logic div_done;
        logic log_done;
    } t_stat;

endpackage

/* rtl/core/gee_div.sv */
module gee_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gee_pkg::DIV_NW-1:0]  i_dividend,
    input  logic [gee_pkg::DIV_DW-1:0]  i_divisor,
    output logic                        o_done,
    output logic [gee_pkg::DIV_NW-1:0]  o_quotient
);
    import gee_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;
    logic [DIV_DW-1:0] n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NW-1]};
        ge     = (rem_sh >= {1'b0, r_div});
        n_rem  = ge ? DIV_DW'(rem_sh - {1'b0, r_div}) : rem_sh[DIV_DW-1:0];
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/gee_log2.sv */
module gee_log2 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [15:0]                i_x,
    output logic                       o_done,
    output logic [gee_pkg::LOG_W-1:0]  o_log
);
    import gee_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [3:0]  r_e;
    logic [23:0] r_frac;
    logic [31:0] r_y;
    logic [3:0]  msb;
    logic [31:0] y_init;
    logic [63:0] sq;
    logic [32:0] sq_sh;

    // Position of the leading one and the normalized mantissa in Q1.31.
    always_comb begin
        msb = '0;
        for (int i = 0; i < 16; i++) begin
            if (i_x[i]) begin
                msb = 4'(i);
            end
        end
        y_init = {i_x, 16'b0} << (4'd15 - msb);
    end

    // One squaring step gives one fraction bit.
    always_comb begin
        sq    = r_y * r_y;
        sq_sh = sq[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd24;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_e    <= msb;
            r_y    <= y_init;
            r_frac <= '0;
        end else if (r_busy) begin
            r_frac <= {r_frac[22:0], sq_sh[32]};
            r_y    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        end
    end

    assign o_done = r_done;
    assign o_log  = {r_e, r_frac};

endmodule

/* rtl/core/gee_datapath.sv */
module gee_datapath #(
    parameter int SAMPLE_TARGET = 16,
    parameter int MAX_ENTRIES   = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gee_pkg::t_cfg   i_cfg,
    input  logic            i_restart,
    input  gee_pkg::t_cmd   i_cmd,
    output gee_pkg::t_stat  o_stat,
    input  logic [31:0]     i_raw_level,
    input  logic [31:0]     i_raw_intensity,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [19:0]     o_gamma_q12,
    output logic [4:0]      o_samples_used,
    output logic            o_used_default,
    output logic            o_exact_linear
);
    import gee_pkg::*;

    localparam int          CW      = $clog2(2 * SAMPLE_TARGET);
    localparam logic [16:0] ENT_MAX = 17'(MAX_ENTRIES);
    // Reciprocal of the sample target, exact for every 17-bit entry count.
    localparam int          INC_SH  = 17 + $clog2(SAMPLE_TARGET);
    localparam logic [18:0] INC_MUL = 19'(((longint'(1) << INC_SH) +
                                           longint'(SAMPLE_TARGET) - 1) /
                                          longint'(SAMPLE_TARGET));

    logic [31:0]       r_raw_level;
    logic [31:0]       r_raw_int;
    logic [15:0]       r_h;
    logic [15:0]       r_f;
    logic [16:0]       r_entry;
    logic [16:0]       r_nsi;
    logic [31:0]       r_sum;
    logic [CW-1:0]     r_cnt;
    logic              r_origin;
    logic [LOG_W-1:0]  r_lf;
    logic [LOG_W-1:0]  r_lfm;
    logic [LOG_W-1:0]  r_lh;
    logic [LOG_W-1:0]  r_lhm;
    t_div_sel          r_div_sel;
    t_log_sel          r_log_sel;
    logic              r_out_valid;
    logic [19:0]       r_gamma;
    logic [4:0]        r_samples;
    logic              r_default;
    logic              r_linear;

    logic [16:0]       n_eff;
    logic [35:0]       inc_prod;
    logic [35:0]       inc_sh;
    logic [16:0]       incr;
    logic [4:0]        bits_eff;
    logic [15:0]       maxh;
    logic [15:0]       byte_int;
    logic [15:0]       byte_lvl;
    logic [15:0]       f_fmt32;
    logic [LOG_W:0]    num;
    logic [LOG_W:0]    den;
    logic [LOG_W-1:0]  an;
    logic [LOG_W-1:0]  ad;
    logic              ratio_neg;
    logic [23:0]       ratio_mag;
    logic [31:0]       mag;
    logic              linear;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [15:0]       log_x;
    logic              div_done;
    logic [DIV_NW-1:0] div_q;
    logic              log_done;
    logic [LOG_W-1:0]  log_q;
    logic [19:0]       mean_gamma;
    logic [4:0]        samples_sat;

    // Effective configuration.
    always_comb begin
        if (i_cfg.table_entries == 17'd0) begin
            n_eff = 17'd1;
        end else if (i_cfg.table_entries > ENT_MAX) begin
            n_eff = ENT_MAX;
        end else begin
            n_eff = i_cfg.table_entries;
        end
        // Sample spacing is the entry count over the target, at least one.
        inc_prod = {19'd0, n_eff} * {17'd0, INC_MUL};
        inc_sh   = inc_prod >> INC_SH;
        incr     = (inc_sh == '0) ? 17'd1 : inc_sh[16:0];
        if (i_cfg.index_bits == 5'd0) begin
            bits_eff = 5'd1;
        end else if (i_cfg.index_bits > 5'd16) begin
            bits_eff = 5'd16;
        end else begin
            bits_eff = i_cfg.index_bits;
        end
        maxh     = i_cfg.table_kind ? ~(LEVEL_MAX << bits_eff) : LEVEL_MAX;
        byte_int = {r_raw_int[7:0], r_raw_int[7:0]};
        byte_lvl = {r_raw_level[7:0], r_raw_level[7:0]};
        // A 32-bit intensity over 65537: the upper half, one less when the
        // lower half is smaller than it.
        f_fmt32  = r_raw_int[31:16] -
                   {15'd0, (r_raw_int[15:0] < r_raw_int[31:16])};
    end

    // Log differences and the saturated ratio of one sample.
    always_comb begin
        num       = {1'b0, r_lf} - {1'b0, r_lfm};
        den       = {1'b0, r_lh} - {1'b0, r_lhm};
        an        = num[LOG_W] ? LOG_W'(-num) : num[LOG_W-1:0];
        ad        = den[LOG_W] ? LOG_W'(-den) : den[LOG_W-1:0];
        ratio_neg = num[LOG_W] ^ den[LOG_W];
        if (ratio_neg) begin
            ratio_mag = (div_q > DIV_NW'(RATIO_NEG_MAX)) ? RATIO_NEG_MAX : div_q[23:0];
        end else begin
            ratio_mag = (div_q > DIV_NW'(RATIO_POS_MAX)) ? RATIO_POS_MAX : div_q[23:0];
        end
        mag    = r_sum[31] ? (32'd0 - r_sum) : r_sum;
        linear = !i_cfg.table_kind && (n_eff == 17'd2) && r_origin &&
                 (r_h == LEVEL_MAX) && (r_f == LEVEL_MAX);
    end

    // Mean of the ratios, saturated to the output range.
    always_comb begin
        if (r_sum[31]) begin
            mean_gamma = (div_q > DIV_NW'(524288)) ? 20'h80000 : (20'd0 - div_q[19:0]);
        end else begin
            mean_gamma = (div_q > DIV_NW'(524287)) ? 20'h7ffff : div_q[19:0];
        end
        samples_sat = (32'(r_cnt) > 32'd31) ? 5'd31 : 5'(r_cnt);
    end

    // Operand selection for the shared divider and logarithm units.
    always_comb begin
        case (i_cmd.div_sel)
            DIV_RATIO: begin
                div_num = DIV_NW'({an, 16'b0});
                div_den = DIV_DW'(ad);
            end
            default: begin
                div_num = DIV_NW'(mag);
                div_den = DIV_DW'({r_cnt, 4'b0});
            end
        endcase
        case (i_cmd.log_sel)
            LOG_F:    log_x = r_f;
            LOG_FMAX: log_x = LEVEL_MAX;
            LOG_H:    log_x = r_h;
            default:  log_x = maxh;
        endcase
    end

    gee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    gee_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_q)
    );

    // Run state and the output word flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= '0;
            r_nsi       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_origin    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_restart) begin
                r_entry  <= '0;
                r_nsi    <= '0;
                r_sum    <= '0;
                r_cnt    <= '0;
                r_origin <= 1'b0;
            end else begin
                if (i_cmd.first) begin
                    r_nsi    <= incr >> 1;
                    r_origin <= (r_h == 16'd0) && (r_f == 16'd0);
                end
                if (i_cmd.step_nsi) begin
                    r_nsi <= r_nsi + incr;
                end
                if (i_cmd.advance) begin
                    r_entry <= r_entry + 17'd1;
                end
                if (div_done && r_div_sel == DIV_RATIO) begin
                    r_sum <= ratio_neg ? (r_sum - 32'(ratio_mag)) : (r_sum + 32'(ratio_mag));
                    r_cnt <= r_cnt + 1'b1;
                end
                if (i_cmd.finish || (div_done && r_div_sel == DIV_MEAN)) begin
                    r_entry     <= '0;
                    r_nsi       <= '0;
                    r_sum       <= '0;
                    r_cnt       <= '0;
                    r_origin    <= 1'b0;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw_level <= i_raw_level;
            r_raw_int   <= i_raw_intensity;
        end
        if (i_cmd.scale) begin
            if (i_cfg.element_format == 2'd0) begin
                r_f <= byte_int;
            end else if (i_cfg.element_format[1]) begin
                r_f <= f_fmt32;
            end else begin
                r_f <= r_raw_int[15:0];
            end
            if (i_cfg.table_kind) begin
                r_h <= r_entry[15:0];
            end else begin
                r_h <= (i_cfg.element_format == 2'd0) ? byte_lvl : r_raw_level[15:0];
            end
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (i_cmd.log_start) begin
            r_log_sel <= i_cmd.log_sel;
        end
        if (log_done) begin
            case (r_log_sel)
                LOG_F:    r_lf  <= log_q;
                LOG_FMAX: r_lfm <= log_q;
                LOG_H:    r_lh  <= log_q;
                default:  r_lhm <= log_q;
            endcase
        end
        if (i_cmd.finish) begin
            r_gamma   <= linear ? ONE_Q12 : DEFAULT_Q12;
            r_samples <= '0;
            r_default <= !linear;
            r_linear  <= linear;
        end else if (div_done && r_div_sel == DIV_MEAN) begin
            r_gamma   <= mean_gamma;
            r_samples <= samples_sat;
            r_default <= 1'b0;
            r_linear  <= 1'b0;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_stat.is_first  = (r_entry == 17'd0);
        o_stat.is_sample = (r_entry == r_nsi);
        o_stat.skip      = (r_h == 16'd0) || (r_f == 16'd0) || (r_h == maxh);
        o_stat.den_zero  = (den == '0);
        o_stat.is_last   = ({1'b0, r_entry} + 18'd1) >= {1'b0, n_eff};
        o_stat.direct    = linear || (r_cnt == '0);
        o_stat.out_full  = r_out_valid;
        o_stat.div_done  = div_done;
        o_stat.log_done  = log_done;
    end

    assign o_out_valid    = r_out_valid;
    assign o_gamma_q12    = r_gamma;
    assign o_samples_used = r_samples;
    assign o_used_default = r_default;
    assign o_exact_linear = r_linear;

endmodule

/* rtl/core/gee_ctrl.sv */
module gee_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gee_pkg::t_stat  i_stat,
    output gee_pkg::t_cmd   o_cmd
);
    import gee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_FIRST,
        S_CHECK,
        S_LOG,
        S_RATIO,
        S_RDIV,
        S_END,
        S_MDIV
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_log_sel r_lsel;
    t_log_sel n_lsel;
    t_cmd     cmd;

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        n_lsel        = r_lsel;
        cmd           = '0;
        cmd.div_sel   = DIV_RATIO;
        cmd.log_sel   = r_lsel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SCALE;
                end
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = S_FIRST;
            end
            S_FIRST: begin
                // The first entry of a run sets the sample position.
                if (i_stat.is_first) begin
                    cmd.first = 1'b1;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.is_sample) begin
                    cmd.step_nsi = 1'b1;
                    if (i_stat.skip) begin
                        n_state = S_END;
                    end else begin
                        cmd.log_start = 1'b1;
                        cmd.log_sel   = LOG_F;
                        n_lsel        = LOG_F;
                        n_state       = S_LOG;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_LOG: begin
                // Four logarithms in turn: f, full scale, h, maximum level.
                if (i_stat.log_done) begin
                    unique case (r_lsel)
                        LOG_F: begin
                            cmd.log_start = 1'b1;
                            cmd.log_sel   = LOG_FMAX;
                            n_lsel        = LOG_FMAX;
                        end
                        LOG_FMAX: begin
                            cmd.log_start = 1'b1;
                            cmd.log_sel   = LOG_H;
                            n_lsel        = LOG_H;
                        end
                        LOG_H: begin
                            cmd.log_start = 1'b1;
                            cmd.log_sel   = LOG_HMAX;
                            n_lsel        = LOG_HMAX;
                        end
                        default: begin
                            n_state = S_RATIO;
                        end
                    endcase
                end
            end
            S_RATIO: begin
                if (i_stat.den_zero) begin
                    n_state = S_END;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_RATIO;
                    n_state       = S_RDIV;
                end
            end
            S_RDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (!i_stat.is_last) begin
                    cmd.advance = 1'b1;
                    n_state     = S_IDLE;
                end else if (!i_stat.out_full) begin
                    if (i_stat.direct) begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_MEAN;
                        n_state       = S_MDIV;
                    end
                end
            end
            S_MDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lsel  <= LOG_F;
        end else begin
            r_state <= n_state;
            r_lsel  <= n_lsel;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

/* rtl/core/gamma_exponent_estimator_top.sv */
// Gamma exponent estimator. Calibration table entries arrive one word at a time on
// the slave stream; after the last entry of a run one result word leaves on the master
// stream with the mean power-law exponent in signed Q8.12, or a fixed value if no
// sample was taken or the table is exactly linear. One entry is taken at a time. An
// unsampled entry runs neither unit, whatever the element width. A sampled entry that
// is not skipped adds four runs of the 24-step squaring logarithm unit and, unless the
// h difference is zero, one run of the 48-step serial divider for the ratio; the last
// entry adds a divider run for the mean unless the value is fixed. A new entry is taken
// while the previous result still waits on the master side; only the last entry of a
// run holds until that result has left. Any register write restarts the current run.
module gamma_exponent_estimator_top #(
    parameter int SAMPLE_TARGET = 16,
    parameter int MAX_ENTRIES   = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // raw_level[31:0], raw_intensity[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // gamma_q12[19:0], samples_used[24:20], zeros
    output logic [1:0]  m_axis_tuser,   // used_default[0], exact_linear[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gee_pkg::*;

    t_cfg        r_cfg;
    logic        cfg_we;
    logic [1:0]  reg_idx;
    t_cmd        cmd;
    t_stat       stat;
    logic [19:0] gamma_q12;
    logic [4:0]  samples_used;
    logic        used_default;
    logic        exact_linear;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_kind     <= 1'b0;
            r_cfg.element_format <= 2'd1;
            r_cfg.index_bits     <= 5'd8;
            r_cfg.table_entries  <= 17'd256;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_TABLE_KIND:     r_cfg.table_kind     <= pwdata[0];
                REG_ELEMENT_FORMAT: r_cfg.element_format <= pwdata[1:0];
                REG_INDEX_BITS:     r_cfg.index_bits     <= pwdata[4:0];
                default:            r_cfg.table_entries  <= pwdata[16:0];
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_idx)
            REG_TABLE_KIND:     prdata = 32'(r_cfg.table_kind);
            REG_ELEMENT_FORMAT: prdata = 32'(r_cfg.element_format);
            REG_INDEX_BITS:     prdata = 32'(r_cfg.index_bits);
            default:            prdata = 32'(r_cfg.table_entries);
        endcase
    end

    gee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gee_datapath #(
        .SAMPLE_TARGET (SAMPLE_TARGET),
        .MAX_ENTRIES   (MAX_ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_restart       (cfg_we),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_raw_level     (s_axis_tdata[31:0]),
        .i_raw_intensity (s_axis_tdata[63:32]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_gamma_q12     (gamma_q12),
        .o_samples_used  (samples_used),
        .o_used_default  (used_default),
        .o_exact_linear  (exact_linear)
    );

    assign m_axis_tdata = {7'b0, samples_used, gamma_q12};
    assign m_axis_tuser = {exact_linear, used_default};

endmodule
